/* rtl/dpsa_pkg.sv */
package dpsa_pkg;

  localparam int VAL_W   = 16;   // raw sample width
  localparam int Q_W     = 24;   // 16.8 fixed point values
  localparam int IDX_W   = 10;   // sample index fields
  localparam int CNT_W   = 11;   // sample count fields
  localparam int LIM_W   = 11;   // limit registers
  localparam int RAD_W   = 2 * Q_W;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam int BASE_START    = 10;
  localparam int SEARCH_MARGIN = 200;
  localparam int DIFF_SPAN     = 10;
  localparam int OSC_LIMIT     = 100;
  localparam int LIMIT_RESET   = 1024;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_TRIGGER_MODE     = 2'd0;
  localparam reg_idx_t REG_RISE_MODE        = 2'd1;
  localparam reg_idx_t REG_SATURATION_LIMIT = 2'd2;
  localparam reg_idx_t REG_DECAY_LIMIT      = 2'd3;

  typedef struct packed {
    logic [Q_W-1:0]   baseline;
    logic [Q_W-1:0]   noise;
    logic             negative_pulse;
    logic [Q_W-1:0]   height;
    logic [IDX_W-1:0] peak_index;
    logic [IDX_W-1:0] trigger_index;
    logic [CNT_W-1:0] rise_count;
    logic [CNT_W-1:0] saturation_count;
    logic [CNT_W-1:0] decay_count;
    logic [IDX_W-1:0] opposite_index;
    logic             saturated;
    logic             noisy;
  } result_t;

endpackage

/* rtl/dpsa_if.sv */
interface dpsa_sample_if import dpsa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] sample;
  logic             last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

interface dpsa_result_if import dpsa_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/dpsa_ram.sv */
module dpsa_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 992
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/dpsa_div.sv */
// Division by a constant through a precomputed reciprocal, one dividend slice per cycle.
module dpsa_div #(
  parameter int DW  = 56,
  parameter int DIV = 150
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  output logic          done,
  output logic [DW-1:0] quotient
);
  localparam int LW  = $clog2(DIV);
  localparam int KW  = DW + LW;               // reciprocal scale
  localparam int MW  = DW + 2;                // reciprocal width
  localparam int CH  = 16;                    // dividend slice per cycle
  localparam int NCH = (DW + CH - 1) / CH;
  localparam int XW  = NCH * CH;
  localparam int AW  = XW + MW;
  localparam int CW  = $clog2(NCH + 1);

  // ceil(2^KW / DIV): exact floor quotient for every DW-bit dividend
  localparam logic [MW-1:0] RECIP =
    MW'(((128'd1 << KW) + 128'(DIV - 1)) / 128'(DIV));

  logic [XW-1:0]    x;
  logic [AW-1:0]    acc;
  logic [CH+MW-1:0] part;
  logic [CW-1:0]    cnt;
  logic             busy;

  assign part     = x[XW-1 -: CH] * RECIP;
  assign quotient = DW'(acc >> KW);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= XW'(dividend);
        acc  <= '0;
        cnt  <= CW'(NCH);
        busy <= 1'b1;
      end else if (busy) begin
        // Horner step: shift in the next partial product, most significant slice first
        acc <= {acc[AW-CH-1:0], {CH{1'b0}}} + AW'(part);
        x   <= {x[XW-CH-1:0], {CH{1'b0}}};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* rtl/dpsa_sqrt.sv */
// Integer square root, one root bit (two radicand bits) per cycle.
module dpsa_sqrt #(
  parameter int RW = 48
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [RW-1:0]   radicand,
  output logic            done,
  output logic [RW/2-1:0] root
);
  localparam int HW = RW / 2;
  localparam int CW = $clog2(HW + 1);

  logic [RW-1:0]   rad;
  logic [HW+1:0]   rem;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [HW+3:0]   t;
  logic [HW+3:0]   trial;

  assign t     = {rem, rad[RW-1:RW-2]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= CW'(HW);
        busy <= 1'b1;
      end else if (busy) begin
        if (t >= trial) begin
          rem  <= (HW+2)'(t - trial);
          root <= {root[HW-2:0], 1'b1};
        end else begin
          rem  <= t[HW+1:0];
          root <= {root[HW-2:0], 1'b0};
        end
        rad <= {rad[RW-3:0], 2'b00};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* rtl/detector_pulse_shape_analyzer.sv */
// Loading: a trace loads at one sample per cycle; the result follows the baseline, noise,
//   polarity and peak passes and the walks around the peak, which read each walked sample
//   once (twice in difference trigger mode).
// Throughput: one trace at a time; input is held off during analysis, set by the single
//   read port of the trace memory, the multicycle reciprocal divider and the square root.
// Reset: synchronous; clears control state, sets configuration registers to defaults, trace memory contents undefined.
module detector_pulse_shape_analyzer
  import dpsa_pkg::*;
#(
  parameter int TRACE_LEN   = 992,
  parameter int BASE_WINDOW = 150
) (
  input  logic                 clk,
  input  logic                 rst,
  dpsa_sample_if.sink          samples,
  dpsa_result_if.source        results,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);
  localparam int AW    = $clog2(TRACE_LEN);
  localparam int WI_W  = $clog2(TRACE_LEN + 1);
  localparam int SUM_W = VAL_W + $clog2(BASE_WINDOW);
  localparam int SQ_W  = 2 * Q_W + $clog2(BASE_WINDOW);
  localparam int EXC_W = Q_W + 2 + $clog2(TRACE_LEN);

  localparam logic [AW-1:0] BASE_FIRST = AW'(BASE_START);
  localparam logic [AW-1:0] BASE_END   = AW'(BASE_START + BASE_WINDOW - 1);
  localparam logic [AW-1:0] SRCH_FIRST = AW'(SEARCH_MARGIN);
  localparam logic [AW-1:0] SRCH_END   = AW'(TRACE_LEN - SEARCH_MARGIN - 1);
  localparam logic [AW-1:0] LAST_IDX   = AW'(TRACE_LEN - 1);

  // Sequencer states
  localparam logic [4:0] S_LOAD = 5'd0;   // take samples into the trace memory
  localparam logic [4:0] S_SUM  = 5'd1;   // sum the baseline window
  localparam logic [4:0] S_DIVB = 5'd2;   // divide for the baseline
  localparam logic [4:0] S_SQ   = 5'd3;   // sum squared deviations
  localparam logic [4:0] S_DIVN = 5'd4;   // divide for the variance
  localparam logic [4:0] S_SQRT = 5'd5;   // root of the variance
  localparam logic [4:0] S_EXC  = 5'd6;   // summed excursion for polarity
  localparam logic [4:0] S_RD0  = 5'd7;   // fetch sample zero, the peak seed
  localparam logic [4:0] S_PK0  = 5'd8;
  localparam logic [4:0] S_PEAK = 5'd9;   // peak and opposite search
  localparam logic [4:0] S_H1   = 5'd10;  // height
  localparam logic [4:0] S_H2   = 5'd11;  // height multiples
  localparam logic [4:0] S_TRIG = 5'd12;  // backward trigger walk
  localparam logic [4:0] S_RSET = 5'd13;
  localparam logic [4:0] S_RISE = 5'd14;  // backward rise and saturation walk
  localparam logic [4:0] S_FSET = 5'd15;
  localparam logic [4:0] S_FWD  = 5'd16;  // forward saturation and decay walk
  localparam logic [4:0] S_DONE = 5'd17;

  logic [4:0] state;

  // Configuration registers
  logic             trig_mode;
  logic             rise_mode;
  logic [LIM_W-1:0] sat_limit;
  logic [LIM_W-1:0] decay_lim;

  // Trace memory
  logic [WI_W-1:0]  widx;
  logic             mem_we;
  logic [AW-1:0]    raddr;
  logic [VAL_W-1:0] rd;
  logic             in_xfer;

  // Linear scan engine: issue one address per cycle, data returns next cycle
  logic [AW-1:0] scan_idx;
  logic [AW-1:0] scan_end;
  logic          scan_iss;
  logic          dv;
  logic          dlast;
  logic [AW-1:0] didx;

  // Squared deviation pipe
  logic              v1, l1, v2, l2;
  logic [Q_W-1:0]    dev1;
  logic [2*Q_W-1:0]  prod;

  // Accumulators and results
  logic [SUM_W-1:0]        sum;
  logic [SQ_W-1:0]         sq;
  logic signed [EXC_W-1:0] exc;
  logic [Q_W-1:0]          base;
  logic [Q_W-1:0]          noise;
  logic                    pos;
  logic [VAL_W-1:0]        pk_val;
  logic [AW-1:0]           pk;
  logic [AW-1:0]           opp;
  logic signed [25:0]      opp_best;
  logic [Q_W-1:0]          h;
  logic [Q_W+1:0]          h3;
  logic [Q_W+3:0]          h9;
  logic [AW-1:0]           trig;
  logic [CNT_W-1:0]        rise;
  logic [CNT_W-1:0]        sat;
  logic [CNT_W-1:0]        decay;
  logic                    rstop, sstop, dstop;
  logic [AW-1:0]           wi;
  logic [1:0]              wph;
  logic [VAL_W-1:0]        ta;
  logic                    ovalid;
  result_t                 res;

  // Divider (shared by baseline and variance) and square root unit
  logic              div_start, div_done;
  logic [SQ_W-1:0]   div_a, div_q;
  logic              sqrt_start, sqrt_done;
  logic [Q_W-1:0]    sqrt_root;

  // Per-sample deviation from baseline
  logic signed [25:0] dsig;
  logic [Q_W-1:0]     dev;
  logic [Q_W+3:0]     d10;
  logic signed [25:0] hsig;
  logic               in_band;
  logic               below_lo;
  logic               below_hi;
  logic               diff_brk;

  assign in_xfer       = samples.valid && samples.ready;
  assign samples.ready = (state == S_LOAD);
  assign mem_we        = in_xfer && (widx < WI_W'(TRACE_LEN));
  assign results.valid = ovalid;
  assign results.data  = res;
  assign pready        = 1'b1;

  assign dsig     = $signed({2'b00, rd, 8'h00}) - $signed({2'b00, base});
  assign dev      = dsig[25] ? Q_W'(-dsig) : dsig[Q_W-1:0];
  assign d10      = (Q_W+4)'({dev, 3'b000}) + (Q_W+4)'({dev, 1'b0});
  assign hsig     = $signed({2'b00, pk_val, 8'h00}) - $signed({2'b00, base});
  assign below_lo = d10 < (Q_W+4)'(h);
  assign below_hi = d10 < h9;
  assign in_band  = !below_lo && (d10 <= h9);
  // Difference trigger: compare sample wi (held in ta) against sample wi-10 (on rd)
  assign diff_brk = (wi >= AW'(DIFF_SPAN)) &&
                    (exc[EXC_W-1] ? (ta > rd) : (ta < rd));

  always_comb begin
    scan_end = BASE_END;
    if (state == S_EXC || state == S_PEAK) begin
      scan_end = SRCH_END;
    end
  end

  always_comb begin
    if (state == S_SUM || state == S_SQ || state == S_EXC || state == S_PEAK) begin
      raddr = scan_idx;
    end else if (state == S_RD0) begin
      raddr = '0;
    end else if (state == S_TRIG && trig_mode && wph == 2'd1) begin
      raddr = wi - AW'(DIFF_SPAN);
    end else begin
      raddr = wi;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TRIGGER_MODE:     prdata = PDATA_W'(trig_mode);
      REG_RISE_MODE:        prdata = PDATA_W'(rise_mode);
      REG_SATURATION_LIMIT: prdata = PDATA_W'(sat_limit);
      REG_DECAY_LIMIT:      prdata = PDATA_W'(decay_lim);
      default:              prdata = '0;
    endcase
  end

  dpsa_ram #(.W(VAL_W), .DEPTH(TRACE_LEN)) u_trace (
    .clk   (clk),
    .we    (mem_we),
    .waddr (widx[AW-1:0]),
    .wdata (samples.sample),
    .raddr (raddr),
    .rdata (rd)
  );

  dpsa_div #(.DW(SQ_W), .DIV(BASE_WINDOW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .done     (div_done),
    .quotient (div_q)
  );

  dpsa_sqrt #(.RW(RAD_W)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (div_q[RAD_W-1:0]),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      widx       <= '0;
      scan_iss   <= 1'b0;
      dv         <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      div_start  <= 1'b0;
      sqrt_start <= 1'b0;
      ovalid     <= 1'b0;
      trig_mode  <= 1'b0;
      rise_mode  <= 1'b0;
      sat_limit  <= LIM_W'(LIMIT_RESET);
      decay_lim  <= LIM_W'(LIMIT_RESET);
    end else begin
      div_start  <= 1'b0;
      sqrt_start <= 1'b0;

      // Register writes
      if (psel && penable && pwrite) begin
        unique case (paddr[3:2])
          REG_TRIGGER_MODE:     trig_mode <= pwdata[0];
          REG_RISE_MODE:        rise_mode <= pwdata[0];
          REG_SATURATION_LIMIT: sat_limit <= pwdata[LIM_W-1:0];
          REG_DECAY_LIMIT:      decay_lim <= pwdata[LIM_W-1:0];
          default: ;
        endcase
      end

      // Scan engine: advance the address, tag the returning data
      dv    <= scan_iss;
      dlast <= (scan_idx == scan_end);
      didx  <= scan_idx;
      if (scan_iss) begin
        scan_idx <= scan_idx + 1'b1;
        if (scan_idx == scan_end) begin
          scan_iss <= 1'b0;
        end
      end

      // Squared deviation pipe: deviation, then product
      v1   <= dv && (state == S_SQ);
      l1   <= dlast;
      dev1 <= dev;
      v2   <= v1;
      l2   <= l1;
      prod <= dev1 * dev1;

      // Drop the result once the sink takes it
      if (ovalid && results.ready) begin
        ovalid <= 1'b0;
      end

      unique case (state)
        S_LOAD: begin
          if (in_xfer) begin
            if (mem_we) begin
              widx <= widx + 1'b1;
            end
            if (samples.last) begin
              widx     <= '0;
              sum      <= '0;
              scan_idx <= BASE_FIRST;
              scan_iss <= 1'b1;
              state    <= S_SUM;
            end
          end
        end
        S_SUM: begin
          if (dv) begin
            sum <= sum + SUM_W'(rd);
            if (dlast) begin
              // Round half up: add half the window before dividing
              div_a     <= SQ_W'({sum + SUM_W'(rd), 8'h00}) + SQ_W'(BASE_WINDOW / 2);
              div_start <= 1'b1;
              state     <= S_DIVB;
            end
          end
        end
        S_DIVB: begin
          if (div_done) begin
            base     <= div_q[Q_W-1:0];
            sq       <= '0;
            scan_idx <= BASE_FIRST;
            scan_iss <= 1'b1;
            state    <= S_SQ;
          end
        end
        S_SQ: begin
          if (v2) begin
            sq <= sq + SQ_W'(prod);
            if (l2) begin
              div_a     <= sq + SQ_W'(prod);
              div_start <= 1'b1;
              state     <= S_DIVN;
            end
          end
        end
        S_DIVN: begin
          if (div_done) begin
            sqrt_start <= 1'b1;
            state      <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            noise    <= sqrt_root;
            exc      <= '0;
            scan_idx <= SRCH_FIRST;
            scan_iss <= 1'b1;
            state    <= S_EXC;
          end
        end
        S_EXC: begin
          if (dv) begin
            exc <= exc + EXC_W'(dsig);
            if (dlast) begin
              state <= S_RD0;
            end
          end
        end
        S_RD0: begin
          state <= S_PK0;
        end
        S_PK0: begin
          // Seed the peak with sample zero, as the search window never holds it
          pk_val   <= rd;
          pk       <= '0;
          opp      <= '0;
          opp_best <= '0;
          pos      <= (exc > 0);
          scan_idx <= SRCH_FIRST;
          scan_iss <= 1'b1;
          state    <= S_PEAK;
        end
        S_PEAK: begin
          if (dv) begin
            if (pos) begin
              if (rd > pk_val) begin
                pk_val <= rd;
                pk     <= didx;
              end else if (dsig < 0 && dsig < opp_best) begin
                opp_best <= dsig;
                opp      <= didx;
              end
            end else begin
              if (rd < pk_val) begin
                pk_val <= rd;
                pk     <= didx;
              end else if (dsig > 0 && dsig > opp_best) begin
                opp_best <= dsig;
                opp      <= didx;
              end
            end
            if (dlast) begin
              state <= S_H1;
            end
          end
        end
        S_H1: begin
          h     <= hsig[25] ? Q_W'(-hsig) : hsig[Q_W-1:0];
          state <= S_H2;
        end
        S_H2: begin
          h3    <= (Q_W+2)'({h, 1'b0}) + (Q_W+2)'(h);
          h9    <= (Q_W+4)'({h, 3'b000}) + (Q_W+4)'(h);
          wi    <= pk;
          wph   <= 2'd0;
          trig  <= '0;
          state <= (pk == '0) ? S_RSET : S_TRIG;
        end
        S_TRIG: begin
          if (!trig_mode) begin
            // Level crossing: stop at the first sample within 30% of the height
            if (wph == 2'd0) begin
              wph <= 2'd1;
            end else begin
              wph <= 2'd0;
              if (d10 <= (Q_W+4)'(h3)) begin
                trig  <= wi;
                state <= S_RSET;
              end else if (wi == AW'(1)) begin
                state <= S_RSET;
              end else begin
                wi <= wi - 1'b1;
              end
            end
          end else begin
            // Slope sign: two reads per sample, at wi and wi-10
            unique case (wph)
              2'd0: wph <= 2'd1;
              2'd1: begin
                ta  <= rd;
                wph <= 2'd2;
              end
              default: begin
                wph <= 2'd0;
                if (diff_brk) begin
                  trig  <= wi;
                  state <= S_RSET;
                end else if (wi == AW'(1)) begin
                  state <= S_RSET;
                end else begin
                  wi <= wi - 1'b1;
                end
              end
            endcase
          end
        end
        S_RSET: begin
          rise  <= rise_mode ? CNT_W'(pk - trig) : '0;
          sat   <= CNT_W'(1);
          rstop <= rise_mode;
          sstop <= 1'b0;
          wi    <= pk - 1'b1;
          wph   <= 2'd0;
          state <= (pk <= AW'(1)) ? S_FSET : S_RISE;
        end
        S_RISE: begin
          if (wph == 2'd0) begin
            wph <= 2'd1;
          end else begin
            wph <= 2'd0;
            if (!rstop && in_band) begin
              rise <= rise + 1'b1;
            end
            if (!sstop && !below_hi) begin
              sat <= sat + 1'b1;
            end
            rstop <= rstop || below_lo;
            sstop <= sstop || below_hi;
            if (((rstop || below_lo) && (sstop || below_hi)) || wi == AW'(1)) begin
              state <= S_FSET;
            end else begin
              wi <= wi - 1'b1;
            end
          end
        end
        S_FSET: begin
          decay <= '0;
          dstop <= 1'b0;
          sstop <= 1'b0;
          wi    <= pk + 1'b1;
          wph   <= 2'd0;
          state <= (pk == LAST_IDX) ? S_DONE : S_FWD;
        end
        S_FWD: begin
          if (wph == 2'd0) begin
            wph <= 2'd1;
          end else begin
            wph <= 2'd0;
            if (!dstop && in_band) begin
              decay <= decay + 1'b1;
            end
            if (!sstop && !below_hi) begin
              sat <= sat + 1'b1;
            end
            dstop <= dstop || below_lo;
            sstop <= sstop || below_hi;
            if (((dstop || below_lo) && (sstop || below_hi)) || wi == LAST_IDX) begin
              state <= S_DONE;
            end else begin
              wi <= wi + 1'b1;
            end
          end
        end
        S_DONE: begin
          // Hold until the output register is free, then load it and reopen the input
          if (!ovalid || results.ready) begin
            res.baseline         <= base;
            res.noise            <= noise;
            res.negative_pulse   <= !pos;
            res.height           <= h;
            res.peak_index       <= IDX_W'(pk);
            res.trigger_index    <= IDX_W'(trig);
            res.rise_count       <= rise;
            res.saturation_count <= sat;
            res.decay_count      <= decay;
            res.opposite_index   <= IDX_W'(opp);
            res.saturated        <= (sat > sat_limit);
            res.noisy            <= (decay > decay_lim) && (pk > opp) &&
                                    ((pk - opp) < AW'(OSC_LIMIT));
            ovalid               <= 1'b1;
            state                <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule
